[hdl/dvc_pkg.sv]
`timescale 1ns / 1ps

package dvc_pkg;

	// Width of the segments-per-gene register.
	localparam int CFG_W = 5;

	// Width of the reported counts; internal counts are truncated to it.
	localparam int CNT_OUT_W = 9;

	// Defaults for the top-level parameters.
	localparam int MAX_GENES_DEF    = 256;
	localparam int MAX_SEGMENTS_DEF = 20;
	localparam int SEGMENT_BITS_DEF = 24;

	// Segments per gene after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

endpackage

[hdl/dvc_ram.sv]
`timescale 1ns / 1ps

module dvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/distinct_vector_counter_top.sv]
`timescale 1ns / 1ps
// A segment beat is compared with every stored unique gene in turn through the single
// table read port, in the sweep, drain and finish states; with no genes stored or the
// table full it goes straight to finish. A result is driven only on the last segment
// of a gene. busy holds off a new beat until the block is through with the last one.
// The receiver cannot stall; result_valid is a one-cycle strobe.
// Reset (arst_n low, asynchronous) empties the group and sets one segment per gene.

module distinct_vector_counter_top #(
	parameter int MAX_GENES    = dvc_pkg::MAX_GENES_DEF,
	parameter int MAX_SEGMENTS = dvc_pkg::MAX_SEGMENTS_DEF,
	parameter int SEGMENT_BITS = dvc_pkg::SEGMENT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Segment beats
	input  logic                           start,
	output logic                           busy,
	input  logic [SEGMENT_BITS-1:0]        segment_value,
	input  logic                           end_of_group,
	// Results
	output logic                           result_valid,
	output logic                           is_duplicate,
	output logic [dvc_pkg::CNT_OUT_W-1:0]  unique_count,
	output logic [dvc_pkg::CNT_OUT_W-1:0]  redundant_count,
	output logic                           group_done,
	output logic                           overflow,
	// Configuration
	input  logic                           cfg_wr_en,
	input  logic [dvc_pkg::CFG_W-1:0]      cfg_wr_data
);

	// Index widths. The table holds MAX_SEGMENTS words per gene, gene-major.
	localparam int JW  = $clog2(MAX_GENES);
	localparam int CW  = $clog2(MAX_GENES + 1);
	localparam int AW  = $clog2(MAX_GENES * MAX_SEGMENTS);
	localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int NW  = (dvc_pkg::CFG_W > SIW) ? dvc_pkg::CFG_W + 1 : SIW + 1;
	localparam int OW  = dvc_pkg::CNT_OUT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;

	// Group state.
	logic [dvc_pkg::CFG_W-1:0] cfg_q;
	logic [CW-1:0]             unique_total_q;
	logic [CW-1:0]             gene_total_q;
	logic [SIW-1:0]            seg_idx_q;
	logic                      ovf_q;

	// Beat under work.
	logic [SEGMENT_BITS-1:0]   seg_q;
	logic                      eog_q;
	logic                      first_q;
	logic                      last_q;
	logic                      room_q;
	logic                      dup_q;
	logic [JW-1:0]             j_q;
	logic [AW-1:0]             addr_q;

	// Read stage: the RAM data for gene j_s1 arrives in the cycle after the read.
	logic                      rd_vld_s1;
	logic [JW-1:0]             j_s1;

	// Result registers.
	logic                      res_vld_q;
	logic                      res_dup_q;
	logic [OW-1:0]             res_uniq_q;
	logic [OW-1:0]             res_red_q;
	logic                      res_done_q;
	logic                      res_ovf_q;

	logic                      accept;
	logic [NW-1:0]             cfg_ext;
	logic [NW-1:0]             nseg;
	logic [NW-1:0]             seg_next;
	logic                      last_now;
	logic                      room_now;
	logic [AW:0]               wbase;
	logic                      tbl_we;
	logic [AW-1:0]             tbl_waddr;
	logic [SEGMENT_BITS-1:0]   tbl_rdata;
	logic                      mask_rdata;
	logic                      new_match;
	logic                      add_unique;
	logic [CW-1:0]             nu;
	logic [CW-1:0]             ng;
	logic                      novf;
	logic [CW+OW-1:0]          nu_ext;
	logic [CW+OW-1:0]          red_ext;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		// A register value of zero acts as one, and values beyond MAX_SEGMENTS
		// act as MAX_SEGMENTS.
		cfg_ext = NW'(cfg_q);
		if (cfg_q == '0) begin
			nseg = NW'(1);
		end else if (cfg_ext > NW'(MAX_SEGMENTS)) begin
			nseg = NW'(MAX_SEGMENTS);
		end else begin
			nseg = cfg_ext;
		end
		seg_next = NW'(seg_idx_q) + NW'(1);
		last_now = (seg_next >= nseg);
		room_now = (gene_total_q < CW'(MAX_GENES));

		// Each segment is written speculatively into the next free slot; it only
		// becomes part of the table if the gene turns out to be new.
		wbase     = (AW+1)'(unique_total_q) * (AW+1)'(MAX_SEGMENTS);
		tbl_we    = accept && room_now;
		tbl_waddr = AW'(wbase + (AW+1)'(seg_idx_q));

		// The match mask is never cleared in memory: on the first segment of a gene
		// the stored bit is ignored and taken as set.
		new_match = (tbl_rdata == seg_q) && (first_q || mask_rdata);

		add_unique = room_q && !dup_q;
		nu         = unique_total_q + CW'(add_unique);
		ng         = gene_total_q + CW'(room_q);
		novf       = ovf_q || !room_q;
		nu_ext     = (CW+OW)'(nu);
		red_ext    = (CW+OW)'(ng - nu);
	end

	dvc_ram #(
		.WIDTH (SEGMENT_BITS),
		.DEPTH (MAX_GENES * MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (segment_value),
		.raddr (addr_q),
		.rdata (tbl_rdata)
	);

	// Mask bit j is written for gene j while gene j+1 is read, so the two ports
	// never meet on one entry within a beat, and a beat ends before the next read.
	dvc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_GENES)
	) u_mask (
		.clk   (clk),
		.we    (rd_vld_s1),
		.waddr (j_s1),
		.wdata (new_match),
		.raddr (j_q),
		.rdata (mask_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cfg_q          <= dvc_pkg::CFG_RESET;
			unique_total_q <= '0;
			gene_total_q   <= '0;
			seg_idx_q      <= '0;
			ovf_q          <= 1'b0;
			rd_vld_s1      <= 1'b0;
			res_vld_q      <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			rd_vld_s1 <= (state_q == ST_SWEEP);
			j_s1      <= j_q;
			if (rd_vld_s1) begin
				dup_q <= dup_q | new_match;
			end

			// A register write abandons the current group.
			if (cfg_wr_en) begin
				cfg_q          <= cfg_wr_data;
				unique_total_q <= '0;
				gene_total_q   <= '0;
				seg_idx_q      <= '0;
				ovf_q          <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						seg_q   <= segment_value;
						eog_q   <= end_of_group;
						first_q <= (seg_idx_q == '0);
						last_q  <= last_now;
						room_q  <= room_now;
						dup_q   <= 1'b0;
						j_q     <= '0;
						addr_q  <= AW'(seg_idx_q);
						if (room_now && (unique_total_q != '0)) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SWEEP: begin
					j_q    <= j_q + JW'(1);
					addr_q <= addr_q + AW'(MAX_SEGMENTS);
					if (CW'(j_q) + CW'(1) == unique_total_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					if (!last_q) begin
						seg_idx_q <= seg_idx_q + SIW'(1);
					end else begin
						seg_idx_q  <= '0;
						res_vld_q  <= 1'b1;
						res_dup_q  <= room_q && dup_q;
						res_uniq_q <= nu_ext[OW-1:0];
						res_red_q  <= red_ext[OW-1:0];
						res_done_q <= eog_q;
						res_ovf_q  <= novf;
						if (eog_q) begin
							unique_total_q <= '0;
							gene_total_q   <= '0;
							ovf_q          <= 1'b0;
						end else begin
							unique_total_q <= nu;
							gene_total_q   <= ng;
							ovf_q          <= novf;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid    = res_vld_q;
	assign is_duplicate    = res_dup_q;
	assign unique_count    = res_uniq_q;
	assign redundant_count = res_red_q;
	assign group_done      = res_done_q;
	assign overflow        = res_ovf_q;

	// A result strobe lasts a single cycle and the block is idle behind it.
	a_res_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |=> !res_vld_q)
		else $error("result strobe held for more than one cycle");

	// Distinct genes never outnumber counted genes, nor counted genes the table.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(unique_total_q <= gene_total_q) && (gene_total_q <= CW'(MAX_GENES)))
		else $error("group counts out of order");

	// Table reads only come back while a beat is still in progress.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> busy)
		else $error("table read data returned while idle");

	// The sweep never reaches a gene slot beyond the stored unique genes.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (CW'(j_q) < unique_total_q))
		else $error("sweep beyond stored unique genes");

	// An accepted beat always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not start work");

endmodule

[verif/dvc_gene_checker.sv]
`timescale 1ns / 1ps

module dvc_gene_checker #(
	parameter int MAX_GENES    = dvc_pkg::MAX_GENES_DEF,
	parameter int MAX_SEGMENTS = dvc_pkg::MAX_SEGMENTS_DEF,
	parameter int SEGMENT_BITS = dvc_pkg::SEGMENT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [SEGMENT_BITS-1:0]        segment_value,
	input  logic                           end_of_group,
	input  logic                           result_valid,
	input  logic                           is_duplicate,
	input  logic [dvc_pkg::CNT_OUT_W-1:0]  unique_count,
	input  logic [dvc_pkg::CNT_OUT_W-1:0]  redundant_count,
	input  logic                           group_done,
	input  logic                           overflow,
	input  logic                           cfg_wr_en,
	input  logic [dvc_pkg::CFG_W-1:0]      cfg_wr_data,
	output int                             mismatch_count,
	output int                             outstanding
);

	typedef struct packed {
		logic                          dup;
		logic [dvc_pkg::CNT_OUT_W-1:0] uniq;
		logic [dvc_pkg::CNT_OUT_W-1:0] redund;
		logic                          done;
		logic                          ovf;
	} gene_verdict_t;

	gene_verdict_t pending_verdicts[$];

	// Model of the group: stored unique genes and the survivors of the running compare.
	logic [SEGMENT_BITS-1:0]   gene_table [MAX_GENES][MAX_SEGMENTS];
	bit                        still_equal [MAX_GENES];
	int                        uniq_total = 0;
	int                        gene_total = 0;
	int                        seg_idx = 0;
	bit                        ovf_flag = 1'b0;
	logic [dvc_pkg::CFG_W-1:0] seg_per_gene = dvc_pkg::CFG_RESET;
	int                        errors = 0;

	task automatic clear_group();
		for (int j = 0; j < MAX_GENES; j++)
			still_equal[j] = 1'b1;
		uniq_total = 0;
		gene_total = 0;
		seg_idx = 0;
		ovf_flag = 1'b0;
	endtask

	// Takes one segment beat and queues the verdict if it completes a gene.
	task automatic absorb_segment(input logic [SEGMENT_BITS-1:0] seg, input logic eog);
		int            nseg;
		int            s;
		bit            room;
		bit            dup;
		gene_verdict_t v;
		nseg = (seg_per_gene == 0) ? 1 :
		       (seg_per_gene > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_per_gene);
		s = (seg_idx >= MAX_SEGMENTS) ? MAX_SEGMENTS - 1 : seg_idx;
		room = gene_total < MAX_GENES;
		dup = 1'b0;
		if (room) begin
			for (int j = 0; j < uniq_total && j < MAX_GENES; j++)
				if (gene_table[j][s] != seg)
					still_equal[j] = 1'b0;
			if (uniq_total < MAX_GENES)
				gene_table[uniq_total][s] = seg;
		end
		if (seg_idx + 1 < nseg) begin
			seg_idx++;
		end else begin
			if (room) begin
				for (int j = 0; j < uniq_total && j < MAX_GENES; j++)
					if (still_equal[j])
						dup = 1'b1;
				if (!dup)
					uniq_total++;
				gene_total++;
			end else begin
				ovf_flag = 1'b1;
			end
			v.dup    = dup;
			v.uniq   = dvc_pkg::CNT_OUT_W'(uniq_total);
			v.redund = dvc_pkg::CNT_OUT_W'(gene_total - uniq_total);
			v.done   = eog;
			v.ovf    = ovf_flag;
			pending_verdicts.push_back(v);
			for (int j = 0; j < MAX_GENES; j++)
				still_equal[j] = 1'b1;
			seg_idx = 0;
			if (eog)
				clear_group();
		end
	endtask

	task automatic compare_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gene_verdict_t got;
		gene_verdict_t want;
		if (!arst_n) begin
			pending_verdicts.delete();
			seg_per_gene = dvc_pkg::CFG_RESET;
			clear_group();
			mismatch_count <= errors;
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				got = {is_duplicate, unique_count, redundant_count, group_done, overflow};
				if (pending_verdicts.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
				end else begin
					want = pending_verdicts.pop_front();
					compare_field("is_duplicate", want.dup, got.dup);
					compare_field("unique_count", want.uniq, got.uniq);
					compare_field("redundant_count", want.redund, got.redund);
					compare_field("group_done", want.done, got.done);
					compare_field("overflow", want.ovf, got.ovf);
				end
			end
			if (cfg_wr_en) begin
				seg_per_gene = cfg_wr_data;
				clear_group();
			end
			if (start && !busy)
				absorb_segment(segment_value, end_of_group);
			mismatch_count <= errors;
			outstanding <= pending_verdicts.size();
		end
	end

endmodule

[verif/tb_distinct_vector_counter_top.sv]
`timescale 1ns / 1ps

module tb_distinct_vector_counter_top;

	localparam int MAX_G = dvc_pkg::MAX_GENES_DEF;
	localparam int MAX_S = dvc_pkg::MAX_SEGMENTS_DEF;
	localparam int SEG_W = dvc_pkg::SEGMENT_BITS_DEF;

	// A sweep of a full table visits up to MAX_G gene slots, then drains and finishes; the settle
	// pause covers the slowest beat that can still be in flight without a result.
	localparam int SETTLE_CYCLES = MAX_G + 16;
	// The slowest correct run is roughly 600 beats, each with a sweep of up to the full
	// table, plus the settle pauses; the limit leaves several times that.
	localparam int CYCLE_LIMIT = 1000000;
	// Genes kept for reuse, so that repeats and near misses can be built.
	localparam int POOL_DEPTH = 64;

	typedef enum {INNER_CLEAR, INNER_SET, INNER_RANDOM} inner_eog_t;
	typedef enum {GENE_FRESH, GENE_REPEAT, GENE_NEAR} gene_kind_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [SEG_W-1:0]              segment_value;
	logic                          end_of_group;
	logic                          result_valid;
	logic                          is_duplicate;
	logic [dvc_pkg::CNT_OUT_W-1:0] unique_count;
	logic [dvc_pkg::CNT_OUT_W-1:0] redundant_count;
	logic                          group_done;
	logic                          overflow;
	logic                          cfg_wr_en;
	logic [dvc_pkg::CFG_W-1:0]     cfg_wr_data;

	int mismatch_count;
	int outstanding;
	int cycle_count;

	// Sender state: beats left in the current burst, and whether the sender has yet
	// paused with results still owed.
	int burst_left = 0;
	bit pressure_done = 1'b0;

	// Effective segments per gene as the block will apply it.
	int eff_segs = 1;

	logic [SEG_W-1:0] gene_buf [MAX_S];
	logic [SEG_W-1:0] gene_pool [POOL_DEPTH][MAX_S];
	int               pool_n = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	distinct_vector_counter_top #(
		.MAX_GENES    (MAX_G),
		.MAX_SEGMENTS (MAX_S),
		.SEGMENT_BITS (SEG_W)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.segment_value   (segment_value),
		.end_of_group    (end_of_group),
		.result_valid    (result_valid),
		.is_duplicate    (is_duplicate),
		.unique_count    (unique_count),
		.redundant_count (redundant_count),
		.group_done      (group_done),
		.overflow        (overflow),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	// The checker watches both channels and the register port, predicts every verdict
	// and compares it; the top only reads its error and outstanding counts.
	dvc_gene_checker #(
		.MAX_GENES    (MAX_G),
		.MAX_SEGMENTS (MAX_S),
		.SEGMENT_BITS (SEG_W)
	) u_gene_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.segment_value   (segment_value),
		.end_of_group    (end_of_group),
		.result_valid    (result_valid),
		.is_duplicate    (is_duplicate),
		.unique_count    (unique_count),
		.redundant_count (redundant_count),
		.group_done      (group_done),
		.overflow        (overflow),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding)
	);

	// Watchdog: if the handshakes ever stop, the run is ended here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Segment words are biased towards the extremes and a few small values, so that
	// accidental matches between genes occur now and then.
	function automatic logic [SEG_W-1:0] rand_segment();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return SEG_W'($urandom_range(0, 3));
			default: return SEG_W'($urandom);
		endcase
	endfunction

	// Sends one beat, opening a new burst first when the current one is used up.
	// Between bursts start is lowered for a random gap; now and then the sender also
	// waits until every owed verdict has come back. The gap is never zero when start
	// is lowered, so start never gets two assignments in one time step.
	task automatic send_beat(input logic [SEG_W-1:0] value, input logic eog);
		int gap;
		bit pause;
		if (burst_left == 0) begin
			pause = (!pressure_done && outstanding != 0) || ($urandom_range(0, 9) == 0);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (pause && gap == 0)
				gap = 1;
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
				if (pause) begin
					if (outstanding != 0)
						pressure_done = 1'b1;
					while (outstanding != 0) @(posedge clk);
				end
			end
			burst_left = $urandom_range(1, 24);
		end
		start <= 1'b1;
		segment_value <= value;
		end_of_group <= eog;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
	endtask

	// Sends the gene held in gene_buf. The end-of-group flag on the last beat closes
	// the group; on inner beats it must be ignored by the block.
	task automatic send_gene(input bit close, input inner_eog_t inner);
		logic eog;
		for (int k = 0; k < eff_segs; k++) begin
			if (k == eff_segs - 1)
				eog = close;
			else if (inner == INNER_SET)
				eog = 1'b1;
			else if (inner == INNER_RANDOM)
				eog = ($urandom_range(0, 3) == 0);
			else
				eog = 1'b0;
			send_beat(gene_buf[k], eog);
		end
	endtask

	// Builds the next gene: a fresh one, an exact repeat of a pooled gene, or a near
	// miss that differs from a pooled gene in a single bit of one segment.
	task automatic compose_gene(input gene_kind_t kind);
		int pick;
		int flip;
		if (pool_n == 0)
			kind = GENE_FRESH;
		pick = (pool_n == 0) ? 0 : $urandom_range(0, pool_n - 1);
		for (int k = 0; k < MAX_S; k++)
			gene_buf[k] = (kind == GENE_FRESH) ? rand_segment() : gene_pool[pick][k];
		if (kind == GENE_NEAR) begin
			flip = $urandom_range(0, eff_segs - 1);
			gene_buf[flip] = gene_buf[flip] ^ (SEG_W'(1) << $urandom_range(0, SEG_W - 1));
		end
		if (kind != GENE_REPEAT && pool_n < POOL_DEPTH) begin
			for (int k = 0; k < MAX_S; k++)
				gene_pool[pool_n][k] = gene_buf[k];
			pool_n++;
		end
	endtask

	// Lowers start, waits for every owed verdict and then lets the slowest possible
	// beat without a result drain out of the block.
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Writes the segments-per-gene register with the block idle. The write also
	// abandons whatever group or partial gene was in progress.
	task automatic write_segments(input logic [dvc_pkg::CFG_W-1:0] value);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		eff_segs = (value == 0) ? 1 : (value > MAX_S) ? MAX_S : int'(value);
		pool_n = 0;
	endtask

	// One random phase at a given register setting. In the fill phase every gene is
	// distinct until the table holds MAX_G of them, then a few more are dropped for
	// overflow before the group closes; the remaining genes start a fresh group.
	// Otherwise genes are mostly repeats and near misses with short groups. A phase
	// may end part way through a gene, which the next register write abandons.
	task automatic run_phase(input logic [dvc_pkg::CFG_W-1:0] spg, input int items,
	                         input bit fill);
		int         sent;
		int         genes;
		int         part;
		bit         close;
		gene_kind_t kind;
		write_segments(spg);
		sent = 0;
		genes = 0;
		while (sent < items) begin
			if (fill) begin
				kind = (genes < MAX_G) ? GENE_FRESH : GENE_REPEAT;
				close = (genes == MAX_G + 3);
			end else begin
				case ($urandom_range(0, 3))
					0:       kind = GENE_FRESH;
					1:       kind = GENE_NEAR;
					default: kind = GENE_REPEAT;
				endcase
				close = ($urandom_range(0, 5) == 0);
			end
			compose_gene(kind);
			// The low byte carries the gene number, so the fill genes are all distinct.
			if (fill && genes < MAX_G) begin
				gene_buf[0] = (SEG_W'($urandom) & ~SEG_W'(8'hFF)) | SEG_W'(genes);
				for (int k = 0; k < MAX_S; k++)
					if (pool_n > 0 && genes < POOL_DEPTH)
						gene_pool[pool_n - 1][k] = gene_buf[k];
			end
			send_gene(close, INNER_RANDOM);
			sent += eff_segs;
			genes++;
		end
		if (eff_segs > 1 && $urandom_range(0, 1) == 1) begin
			compose_gene(GENE_FRESH);
			part = $urandom_range(1, eff_segs - 1);
			for (int k = 0; k < part; k++)
				send_beat(gene_buf[k], 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		segment_value = '0;
		end_of_group = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the reset setting of one segment per gene: the two
		// extreme words, each seen again as a duplicate, the last closing the group.
		gene_buf[0] = '0;
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[0] = '1;
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[0] = '0;
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[0] = '1;
		send_gene(1'b1, INNER_CLEAR);

		// Three segments per gene: a gene, one that differs only in its last segment,
		// one that differs only in its first, and the first gene again. The repeat
		// carries the end-of-group flag on its inner segments too, where it is ignored.
		write_segments(dvc_pkg::CFG_W'(3));
		gene_buf[0] = '0;
		gene_buf[1] = '1;
		gene_buf[2] = SEG_W'(24'h123456);
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[2] = SEG_W'(24'h123457);
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[0] = SEG_W'(1);
		gene_buf[2] = SEG_W'(24'h123456);
		send_gene(1'b0, INNER_CLEAR);
		gene_buf[0] = '0;
		send_gene(1'b1, INNER_SET);

		// A partial gene left hanging, then abandoned by a write of zero, which the
		// block treats as one segment per gene.
		send_beat('1, 1'b1);
		send_beat('0, 1'b0);
		write_segments(dvc_pkg::CFG_W'(0));
		gene_buf[0] = SEG_W'(5);
		send_gene(1'b0, INNER_CLEAR);
		send_gene(1'b1, INNER_CLEAR);

		// Random part. The fill phase reaches a full table and overflow; the others
		// sweep small, large and out-of-range settings, with the large ones kept short.
		run_phase(dvc_pkg::CFG_W'(1), MAX_G + 10, 1'b1);
		run_phase(dvc_pkg::CFG_W'(2), 60, 1'b0);
		run_phase(dvc_pkg::CFG_W'(31), 60, 1'b0);
		run_phase(dvc_pkg::CFG_W'(3), 60, 1'b0);
		run_phase(dvc_pkg::CFG_W'(0), 30, 1'b0);
		run_phase(dvc_pkg::CFG_W'(20), 40, 1'b0);
		run_phase(dvc_pkg::CFG_W'(7), 35, 1'b0);

		quiesce();
		if (mismatch_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
